FILE: rtl/assert_macros.svh
// Assertion macros for the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: rtl/tcw_pkg.sv
// Types and constants for the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int ADDR_MAX_W = 12;

    localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE   = 8'd32;

    typedef enum logic [1:0] {
        KIND_PUT  = 2'd0,
        KIND_READ = 2'd1,
        KIND_MOVE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_PUT_WR,
        ST_MV_WR0,
        ST_MV_RD1,
        ST_MV_WR1,
        ST_BLK_RD,
        ST_BLK_WR,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [ADDR_MAX_W-1:0] addr;
        logic [CELL_W-1:0]     wdata;
    } t_ram_req;

    typedef struct packed {
        logic [ROW_W-1:0]  pointer_row;
        logic [COL_W-1:0]  pointer_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_data;
    } t_result;

endpackage

FILE: rtl/tcw_ram.sv
// Single-port screen cell memory with registered read data.
module tcw_ram #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  tcw_pkg::t_ram_req            i_req,
    output logic [tcw_pkg::CELL_W-1:0]   o_rdata
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr[ADDR_W-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr[ADDR_W-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tcw_ctrl.sv
// Sequencer for cursor, pointer, screen clear and cell read-modify-write.
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_valid,
    output logic                         o_s_ready,
    input  logic [1:0]                   i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_character,
    input  logic [tcw_pkg::IDX_W-1:0]    i_cell_index,
    input  logic [7:0]                   i_move_x,
    input  logic [7:0]                   i_move_y,
    output tcw_pkg::t_ram_req            o_ram_req,
    input  logic [tcw_pkg::CELL_W-1:0]   i_rdata,
    input  logic                         i_slot_free,
    output logic                         o_res_vld,
    output tcw_pkg::t_result             o_res
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    t_state              r_state, n_state;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_pcol, n_pcol;
    logic [ROW_W-1:0]    r_prow, n_prow;
    logic [ADDR_W-1:0]   r_sweep, n_sweep;
    logic [1:0]          r_kind, n_kind;
    logic [CHAR_W-1:0]   r_ch, n_ch;
    logic [7:0]          r_dx, n_dx;
    logic [7:0]          r_dy, n_dy;
    logic                r_rd_ok, n_rd_ok;

    logic [ROW_W:0]          w_row_inc;
    logic [COL_W:0]          w_col_inc;
    logic                    w_wrap_row;
    logic                    w_wrap_col;
    logic                    w_sweep_last;
    logic                    w_idx_ok;
    logic [ADDR_MAX_W-1:0]   w_cur_addr;
    logic [ADDR_MAX_W-1:0]   w_ptr_addr;
    logic [8:0]              w_pcol_new;
    logic [8:0]              w_prow_new;

    function automatic logic [ADDR_MAX_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        cell_addr = ADDR_MAX_W'(row) * ADDR_MAX_W'(COLUMNS) + ADDR_MAX_W'(col);
    endfunction

    function automatic logic [8:0] clamp_pos(
        input logic [8:0] cur,
        input logic [7:0] off,
        input logic [8:0] lim
    );
        logic signed [8:0] p;
        p = $signed(cur) + $signed({off[7], off});
        if (p >= $signed(lim)) begin
            p = $signed(lim - 9'd1);
        end
        if (p < 0) begin
            p = '0;
        end
        clamp_pos = p;
    endfunction

    function automatic logic [CELL_W-1:0] swap_attr(input logic [CELL_W-1:0] v);
        swap_attr = {v[11:8], v[15:12], v[7:0]};
    endfunction

    assign w_row_inc    = {1'b0, r_row} + (ROW_W+1)'(1);
    assign w_col_inc    = {1'b0, r_col} + (COL_W+1)'(1);
    assign w_wrap_row   = (w_row_inc >= (ROW_W+1)'(ROWS));
    assign w_wrap_col   = (w_col_inc >= (COL_W+1)'(COLUMNS));
    assign w_sweep_last = (r_sweep == ADDR_W'(CELLS - 1));
    assign w_idx_ok     = ({1'b0, i_cell_index} < ADDR_MAX_W'(CELLS));
    assign w_cur_addr   = cell_addr(r_row, r_col);
    assign w_ptr_addr   = cell_addr(r_prow, r_pcol);
    assign w_pcol_new   = clamp_pos(9'(r_pcol), r_dx, 9'(COLUMNS));
    assign w_prow_new   = clamp_pos(9'(r_prow), r_dy, 9'(ROWS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (w_sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_valid) begin
                    case (i_kind)
                        KIND_PUT: begin
                            if (i_character == '0) begin
                                n_state = ST_FIN;
                            end else if (i_character == NEWLINE) begin
                                n_state = w_wrap_row ? ST_BLK_RD : ST_FIN;
                            end else begin
                                n_state = ST_PUT_WR;
                            end
                        end
                        KIND_MOVE: n_state = ST_MV_WR0;
                        default:   n_state = ST_FIN;
                    endcase
                end
            end
            ST_PUT_WR: begin
                n_state = (w_wrap_col && w_wrap_row) ? ST_BLK_RD : ST_FIN;
            end
            ST_MV_WR0: n_state = ST_MV_RD1;
            ST_MV_RD1: n_state = ST_MV_WR1;
            ST_MV_WR1: n_state = ST_FIN;
            ST_BLK_RD: n_state = ST_BLK_WR;
            ST_BLK_WR: n_state = w_sweep_last ? ST_FIN : ST_BLK_RD;
            ST_FIN: begin
                if (i_slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_ready       = 1'b0;
        o_res_vld       = 1'b0;
        o_ram_req.we    = 1'b0;
        o_ram_req.re    = 1'b0;
        o_ram_req.addr  = w_cur_addr;
        o_ram_req.wdata = '0;
        case (r_state)
            ST_CLR: begin
                o_ram_req.we   = 1'b1;
                o_ram_req.addr = ADDR_MAX_W'(r_sweep);
            end
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    case (i_kind)
                        KIND_PUT: begin
                            o_ram_req.re = (i_character != '0) && (i_character != NEWLINE);
                        end
                        KIND_READ: begin
                            o_ram_req.re   = w_idx_ok;
                            o_ram_req.addr = ADDR_MAX_W'(i_cell_index);
                        end
                        KIND_MOVE: begin
                            o_ram_req.re   = 1'b1;
                            o_ram_req.addr = w_ptr_addr;
                        end
                        default: o_ram_req.re = 1'b0;
                    endcase
                end
            end
            ST_PUT_WR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.wdata = {i_rdata[15:8], r_ch};
            end
            ST_MV_WR0, ST_MV_WR1: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.addr  = w_ptr_addr;
                o_ram_req.wdata = swap_attr(i_rdata);
            end
            ST_MV_RD1: begin
                o_ram_req.re   = 1'b1;
                o_ram_req.addr = w_ptr_addr;
            end
            ST_BLK_RD: begin
                o_ram_req.re   = 1'b1;
                o_ram_req.addr = ADDR_MAX_W'(r_sweep);
            end
            ST_BLK_WR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.addr  = ADDR_MAX_W'(r_sweep);
                o_ram_req.wdata = {i_rdata[15:8], SPACE};
            end
            ST_FIN: o_res_vld = i_slot_free;
            default: o_res_vld = 1'b0;
        endcase
    end

    assign o_res.cell_data   = ((r_kind == KIND_READ) && r_rd_ok) ? i_rdata : '0;
    assign o_res.cursor_col  = r_col;
    assign o_res.cursor_row  = r_row;
    assign o_res.pointer_col = r_pcol;
    assign o_res.pointer_row = r_prow;

    // cursor, pointer and item registers
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_pcol  = r_pcol;
        n_prow  = r_prow;
        n_sweep = r_sweep;
        n_kind  = r_kind;
        n_ch    = r_ch;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_rd_ok = r_rd_ok;
        case (r_state)
            ST_CLR: begin
                if (!w_sweep_last) n_sweep = r_sweep + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_kind  = i_kind;
                    n_ch    = i_character;
                    n_dx    = i_move_x;
                    n_dy    = i_move_y;
                    n_rd_ok = w_idx_ok;
                    if ((i_kind == KIND_PUT) && (i_character == NEWLINE)) begin
                        n_col = '0;
                        if (w_wrap_row) begin
                            n_row   = '0;
                            n_sweep = '0;
                        end else begin
                            n_row = w_row_inc[ROW_W-1:0];
                        end
                    end
                end
            end
            ST_PUT_WR: begin
                if (w_wrap_col) begin
                    n_col = '0;
                    if (w_wrap_row) begin
                        n_row   = '0;
                        n_sweep = '0;
                    end else begin
                        n_row = w_row_inc[ROW_W-1:0];
                    end
                end else begin
                    n_col = w_col_inc[COL_W-1:0];
                end
            end
            ST_MV_WR0: begin
                n_pcol = w_pcol_new[COL_W-1:0];
                n_prow = w_prow_new[ROW_W-1:0];
            end
            ST_BLK_WR: begin
                if (!w_sweep_last) n_sweep = r_sweep + ADDR_W'(1);
            end
            default: n_sweep = r_sweep;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_sweep <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_pcol  <= COL_W'(COLUMNS / 2);
            r_prow  <= ROW_W'(ROWS / 2);
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_col   <= n_col;
            r_row   <= n_row;
            r_pcol  <= n_pcol;
            r_prow  <= n_prow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_ch    <= n_ch;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_rd_ok <= n_rd_ok;
    end

endmodule

FILE: rtl/text_console_writer_with_pointer_top.sv
// Top level of the text console writer with pointer.
//
// Input beats arrive on s_axis: tuser carries the item kind (put character,
// read cell, pointer move), tdata the character, cell index and the signed
// pointer offsets. Every beat gives exactly one result beat on m_axis with the
// cell read (zero unless an in-range read), the text cursor and the pointer
// position. Screen cells live in one single-port memory with registered read
// data; after the clear every cell update is a read followed by a write of
// that same cell. A read, a newline, a zero character or an unused kind goes
// from idle straight to the finish step; a put adds a read-modify-write of
// the cursor cell and a pointer move two, on the old and the new pointer cell,
// on the memory port. A put or newline that runs off the last row adds a
// blanking pass, one read and one write per cell, with input held off.
// After reset the memory is cleared one cell a cycle, and s_axis_tready
// rises once the clear is done.
// An output register holds a finished result while m_axis stalls; the next
// item is accepted meanwhile and waits in its last step until the register
// frees.
`include "assert_macros.svh"

module text_console_writer_with_pointer_top #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // character[7:0], cell_index[18:8], move_x[26:19], move_y[34:27], zero[39:35]
    input  logic [39:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_data[15:0], cursor_col[22:16], cursor_row[27:23],
    // pointer_col[34:28], pointer_row[39:35]
    output logic [39:0] m_axis_tdata
);
    import tcw_pkg::*;

    t_ram_req           w_ram_req;
    logic [CELL_W-1:0]  w_rdata;
    logic               w_slot_free;
    logic               w_res_vld;
    t_result            w_res;

    logic               r_out_vld;
    t_result            r_out;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .o_s_ready    (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_character  (s_axis_tdata[7:0]),
        .i_cell_index (s_axis_tdata[18:8]),
        .i_move_x     (s_axis_tdata[26:19]),
        .i_move_y     (s_axis_tdata[34:27]),
        .o_ram_req    (w_ram_req),
        .i_rdata      (w_rdata),
        .i_slot_free  (w_slot_free),
        .o_res_vld    (w_res_vld),
        .o_res        (w_res)
    );

    tcw_ram #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_rdata)
    );

    assign w_slot_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_vld) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.pointer_row, r_out.pointer_col,
                            r_out.cursor_row, r_out.cursor_col, r_out.cell_data};

    `ASSERT_NEVER(a_accept_vs_emit, i_clk, i_rst_n, s_axis_tready && w_res_vld)
    `ASSERT_CLK(a_emit_free, i_clk, i_rst_n, w_res_vld |-> w_slot_free)
    `ASSERT_CLK(a_cursor_rng, i_clk, i_rst_n, m_axis_tvalid |-> (r_out.cursor_col < COL_W'(COLUMNS)) && (r_out.cursor_row < ROW_W'(ROWS)))
    `ASSERT_CLK(a_pointer_rng, i_clk, i_rst_n, m_axis_tvalid |-> (r_out.pointer_col < COL_W'(COLUMNS)) && (r_out.pointer_row < ROW_W'(ROWS)))

endmodule

FILE: test/tcw_scoreboard_pkg.sv
// Scoreboard for the text console writer: screen predictor and result checker.
`timescale 1ns / 1ps

package tcw_scoreboard_pkg;
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS_DEF * ROWS_DEF;
    localparam int REPORT_MAX = 10;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELL_COUNT];
        int cur_col;
        int cur_row;
        int ptr_col;
        int ptr_row;
        t_result expected_results [$];
        int mismatches;
        int checked;
        int n_put;
        int n_read;
        int n_move;
        int n_other;
        int n_wrap;
        int n_blank;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cur_col = 0;
            cur_row = 0;
            ptr_col = 40;
            ptr_row = 12;
        endfunction

        function logic [CELL_W-1:0] swap_attr(logic [CELL_W-1:0] v);
            return {v[11:8], v[15:12], v[7:0]};
        endfunction

        function void highlight_pointer();
            int a;
            a = ptr_row * COLUMNS_DEF + ptr_col;
            cells[a] = swap_attr(cells[a]);
        endfunction

        function int clamp_add(int pos, logic signed [7:0] off, int limit);
            int p;
            p = pos + int'(off);
            if (p > limit - 1) p = limit - 1;
            if (p < 0) p = 0;
            return p;
        endfunction

        function void put_char(logic [CHAR_W-1:0] ch);
            int a;
            if (ch == '0) return;
            if (ch == NEWLINE) begin
                cur_col = 0;
                cur_row++;
            end else begin
                a = cur_row * COLUMNS_DEF + cur_col;
                cells[a] = {cells[a][15:8], ch};
                cur_col++;
                if (cur_col == COLUMNS_DEF) begin
                    cur_col = 0;
                    cur_row++;
                    n_wrap++;
                end
            end
            if (cur_row == ROWS_DEF) begin
                foreach (cells[i]) cells[i] = {cells[i][15:8], SPACE};
                cur_col = 0;
                cur_row = 0;
                n_blank++;
            end
        endfunction

        function void note_item(logic [1:0] kind, logic [39:0] data);
            t_result r;
            logic [IDX_W-1:0] idx;
            idx = data[18:8];
            r = '0;
            case (kind)
                KIND_PUT: begin
                    put_char(data[7:0]);
                    n_put++;
                end
                KIND_READ: begin
                    if (int'(idx) < CELL_COUNT) r.cell_data = cells[idx];
                    n_read++;
                end
                KIND_MOVE: begin
                    highlight_pointer();
                    ptr_col = clamp_add(ptr_col, data[26:19], COLUMNS_DEF);
                    ptr_row = clamp_add(ptr_row, data[34:27], ROWS_DEF);
                    highlight_pointer();
                    n_move++;
                end
                default: begin
                    n_other++;
                end
            endcase
            r.cursor_col  = COL_W'(cur_col);
            r.cursor_row  = ROW_W'(cur_row);
            r.pointer_col = COL_W'(ptr_col);
            r.pointer_row = ROW_W'(ptr_row);
            expected_results.push_back(r);
        endfunction

        function void note_mismatch(string field, int want, int got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result %0d: %s expected %0d got %0d", checked, field, want, got);
        endfunction

        function void check_result(logic [39:0] data);
            t_result got;
            t_result want;
            got = t_result'(data);
            checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d: beat %h arrived with nothing outstanding", checked, data);
                return;
            end
            want = expected_results.pop_front();
            if (got.cell_data !== want.cell_data)
                note_mismatch("cell_data", int'(want.cell_data), int'(got.cell_data));
            if (got.cursor_col !== want.cursor_col)
                note_mismatch("cursor_col", int'(want.cursor_col), int'(got.cursor_col));
            if (got.cursor_row !== want.cursor_row)
                note_mismatch("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
            if (got.pointer_col !== want.pointer_col)
                note_mismatch("pointer_col", int'(want.pointer_col), int'(got.pointer_col));
            if (got.pointer_row !== want.pointer_row)
                note_mismatch("pointer_row", int'(want.pointer_row), int'(got.pointer_row));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

FILE: test/tb_top.sv
// Testbench top for the text console writer: stimulus, handshakes and final report.
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;
    import tcw_scoreboard_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int ITEM_TARGET   = 800;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 150;

    typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_THREE_OF_FOUR} t_rx_pattern;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    console_scoreboard sb;
    int results_seen = 0;
    int items_sent = 0;
    int burst_left = 0;
    int stall_cycles = 0;

    text_console_writer_with_pointer_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                results_seen++;
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int hold_left;
        int cyc;
        bit hold_done;
        t_rx_pattern pattern;
        hold_left = 0;
        cyc = 0;
        hold_done = 1'b0;
        pattern = RX_FREE;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0) pattern = t_rx_pattern'($urandom_range(0, 3));
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (pattern)
                    RX_FREE:   m_axis_tready <= 1'b1;
                    RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
                    default:   m_axis_tready <= (cyc % 4 != 0);
                endcase
            end
        end
    end

    function automatic logic [39:0] pack_beat(logic [7:0] ch, logic [10:0] idx,
                                              logic [7:0] mx, logic [7:0] my);
        return {5'b0, my, mx, idx, ch};
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == NEWLINE);
        return c;
    endfunction

    task automatic pause_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic send_beat(logic [1:0] kind, logic [39:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            pause_sender($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic put(logic [7:0] ch);
        send_beat(KIND_PUT, pack_beat(ch, 11'($urandom), 8'($urandom), 8'($urandom)));
        items_sent++;
    endtask

    task automatic read_cell(logic [10:0] idx);
        send_beat(KIND_READ, pack_beat(8'($urandom), idx, 8'($urandom), 8'($urandom)));
        items_sent++;
    endtask

    task automatic move(logic [7:0] mx, logic [7:0] my);
        send_beat(KIND_MOVE, pack_beat(8'($urandom), 11'($urandom), mx, my));
        items_sent++;
    endtask

    task automatic drain_results();
        pause_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_group();
        int r;
        int n;
        logic [7:0] mx;
        logic [7:0] my;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(75, 100) : $urandom_range(1, 20);
            repeat (n) put(text_char());
            if ($urandom_range(0, 9) < 7) put(NEWLINE);
        end else if (r < 50) begin
            repeat ($urandom_range(1, 10)) put(NEWLINE);
        end else if (r < 68) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 3) == 0) begin
                    mx = 8'($urandom);
                    my = 8'($urandom);
                end else begin
                    mx = 8'($urandom_range(0, 16) - 8);
                    my = 8'($urandom_range(0, 16) - 8);
                end
                move(mx, my);
            end
        end else if (r < 88) begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 2))
                    0: read_cell(11'($urandom));
                    1: read_cell(11'(sb.cur_row * COLUMNS_DEF + $urandom_range(0, 79)));
                    default: read_cell(11'(sb.ptr_row * COLUMNS_DEF + sb.ptr_col));
                endcase
            end
        end else begin
            if ($urandom_range(0, 1) == 1)
                send_beat(KIND_SPARE, pack_beat(8'($urandom), 11'($urandom),
                                                8'($urandom), 8'($urandom)));
            else
                send_beat(KIND_PUT, pack_beat(8'h00, 11'($urandom),
                                              8'($urandom), 8'($urandom)));
        end
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        read_cell(11'd0);
        read_cell(11'd1999);
        read_cell(11'd2000);
        read_cell(11'h7FF);
        put(8'd65);
        put(8'hFF);
        put(8'd1);
        put(8'h00);
        put(NEWLINE);
        read_cell(11'd0);
        read_cell(11'd1);
        send_beat(KIND_SPARE, {5'b0, 35'h7_FFFF_FFFF});
        move(8'h7F, 8'h7F);
        move(8'h80, 8'h80);
        move(8'h00, 8'h00);
        move(8'd40, 8'd12);
        move(8'hFF, 8'd1);
        read_cell(11'd1079);
        read_cell(11'd1999);

        while (items_sent < ITEM_TARGET) begin
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                drain_results();
                paused = 1'b1;
            end
            random_group();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d puts (%0d line wraps, %0d screen blanks), %0d reads,",
                 sb.n_put, sb.n_wrap, sb.n_blank, sb.n_read);
        $display("%0d moves, %0d unused-kind beats; %0d results checked, %0d mismatches",
                 sb.n_move, sb.n_other, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_with_pointer_top.sv
test/tcw_scoreboard_pkg.sv
test/tb_top.sv
